FILE: rtl/trs_pkg.sv
// Shared types and constants of the tiled region statistics unit.
// No dependencies; trs_dp, trs_ctrl, the top and the checker import this package.
package trs_pkg;

  localparam int unsigned TRS_MAX_ROWS = 256;
  localparam int unsigned TRS_MAX_COLS = 256;
  localparam int unsigned TRS_MAX_TPS  = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned SIDE_W   = 4;
  localparam int unsigned TILE_W   = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned VAR_W    = 48;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned CELL_W   = SAMPLE_W + 1;

  localparam int unsigned TDO_W    = 144;
  localparam int unsigned MEAN_LSB = 0;
  localparam int unsigned VAR_LSB  = MEAN_LSB + MEAN_W;
  localparam int unsigned MIN_LSB  = VAR_LSB + VAR_W;
  localparam int unsigned MAX_LSB  = MIN_LSB + SAMPLE_W;
  localparam int unsigned ANOM_LSB = MAX_LSB + SAMPLE_W;
  localparam int unsigned CNT_LSB  = ANOM_LSB + CNT_W;
  localparam int unsigned PAD_W    = TDO_W - (CNT_LSB + CNT_W);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_SIDE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_H    = 2'd0,
    DIV_W    = 2'd1,
    DIV_MEAN = 2'd2,
    DIV_VAR  = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic     load_we;
    logic     div_go;
    div_sel_e div_sel;
    logic     tile_first;
    logic     tile_next;
    logic     scan_go;
    logic     pass2;
  } trs_cmd_t;

  typedef struct packed {
    logic load_end;
    logic div_done;
    logic scan_done;
    logic tile_empty;
    logic tile_last;
  } trs_stat_t;

endpackage

FILE: rtl/trs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module trs_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/trs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module trs_div #(
  parameter int unsigned NW = 65,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quot_o,
  output logic          done_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_q;
  logic [DW-1:0]   rem_q, dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     tmp, diff;
  logic            ge;

  assign tmp  = {rem_q, q_q[NW-1]};
  assign ge   = tmp >= {1'b0, dvs_q};
  assign diff = tmp - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : tmp[DW-1:0];
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

FILE: rtl/trs_dp.sv
// Datapath: config registers, cell store, tile bounds, scan pipeline,
// accumulators and the shared divider. Depends on trs_pkg, trs_ram, trs_div.
module trs_dp #(
  parameter int unsigned MAX_ROWS = trs_pkg::TRS_MAX_ROWS,
  parameter int unsigned MAX_COLS = trs_pkg::TRS_MAX_COLS,
  parameter int unsigned MAX_TPS  = trs_pkg::TRS_MAX_TPS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  trs_pkg::trs_cmd_t                    cmd_i,
  output trs_pkg::trs_stat_t                   stat_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [trs_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [trs_pkg::SAMPLE_W-1:0]         sample_i,
  input  logic                                 anomaly_i,
  output logic [trs_pkg::IDX_W-1:0]            tile_index_o,
  output logic [trs_pkg::MEAN_W-1:0]           tile_mean_o,
  output logic [trs_pkg::VAR_W-1:0]            tile_variance_o,
  output logic [trs_pkg::SAMPLE_W-1:0]         tile_min_o,
  output logic [trs_pkg::SAMPLE_W-1:0]         tile_max_o,
  output logic [trs_pkg::CNT_W-1:0]            anomaly_total_o,
  output logic [trs_pkg::CNT_W-1:0]            cell_total_o
);
  import trs_pkg::*;

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned NW    = $clog2(CELLS + 1);
  localparam int unsigned SUMW  = SAMPLE_W + NW;
  localparam int unsigned DVW   = VAR_W + NW;
  localparam int unsigned DW    = (NW > SIDE_W) ? NW : SIDE_W;

  // config
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [SIDE_W-1:0] side_q;
  logic [RW-1:0]     rows;
  logic [CW-1:0]     cols;
  logic [SIDE_W-1:0] side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(64);
      cols_q <= CFG_W'(64);
      side_q <= SIDE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
        REG_SIDE: side_q <= cfg_data_i[SIDE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (rows_q == '0)                        rows = RW'(1);
    else if (32'(rows_q) > 32'(MAX_ROWS))    rows = RW'(MAX_ROWS);
    else                                     rows = RW'(rows_q);
    if (cols_q == '0)                        cols = CW'(1);
    else if (32'(cols_q) > 32'(MAX_COLS))    cols = CW'(MAX_COLS);
    else                                     cols = CW'(cols_q);
    if (side_q == '0)                        side = SIDE_W'(1);
    else if (32'(side_q) > 32'(MAX_TPS))     side = SIDE_W'(MAX_TPS);
    else                                     side = side_q;
  end

  // load position
  logic [RW-1:0] ld_row_q;
  logic [CW-1:0] ld_col_q;
  logic          ld_col_end, ld_row_end;
  logic [AW-1:0] waddr, raddr;

  assign ld_col_end = ({1'b0, ld_col_q} + 1'b1) >= {1'b0, cols};
  assign ld_row_end = ({1'b0, ld_row_q} + 1'b1) >= {1'b0, rows};
  assign waddr      = AW'(32'(ld_row_q) * 32'(MAX_COLS) + 32'(ld_col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
    end else if (cmd_i.load_we) begin
      if (ld_col_end) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_end ? '0 : ld_row_q + RW'(1);
      end else begin
        ld_col_q <= ld_col_q + CW'(1);
      end
    end
  end

  // tile bounds
  logic [TILE_W-1:0] ri_q, ci_q;
  logic [RW-1:0]     h_q, r0_q, r1;
  logic [CW-1:0]     w_q, c0_q, c1;
  logic              last_ri, last_ci;

  assign last_ri = ri_q == TILE_W'(side - SIDE_W'(1));
  assign last_ci = ci_q == TILE_W'(side - SIDE_W'(1));
  assign r1      = last_ri ? rows : r0_q + h_q;
  assign c1      = last_ci ? cols : c0_q + w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= '0;
      ci_q <= '0;
      r0_q <= '0;
      c0_q <= '0;
    end else if (cmd_i.tile_first) begin
      ri_q <= '0;
      ci_q <= '0;
      r0_q <= '0;
      c0_q <= '0;
    end else if (cmd_i.tile_next) begin
      if (last_ci) begin
        ci_q <= '0;
        c0_q <= '0;
        ri_q <= ri_q + TILE_W'(1);
        r0_q <= r0_q + h_q;
      end else begin
        ci_q <= ci_q + TILE_W'(1);
        c0_q <= c0_q + w_q;
      end
    end
  end

  // scan address generator
  logic [RW-1:0] sr_q;
  logic [CW-1:0] sc_q;
  logic          scan_q, pass2_q, rd_v_q, dv_q, sq_v_q;
  logic          sc_end, sr_end;

  assign sc_end = ({1'b0, sc_q} + 1'b1) >= {1'b0, c1};
  assign sr_end = ({1'b0, sr_q} + 1'b1) >= {1'b0, r1};
  assign raddr  = AW'(32'(sr_q) * 32'(MAX_COLS) + 32'(sc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= 1'b0;
      pass2_q <= 1'b0;
      rd_v_q  <= 1'b0;
      dv_q    <= 1'b0;
      sq_v_q  <= 1'b0;
      sr_q    <= '0;
      sc_q    <= '0;
    end else begin
      rd_v_q <= scan_q;
      dv_q   <= rd_v_q && pass2_q;
      sq_v_q <= dv_q;
      if (cmd_i.scan_go) begin
        scan_q  <= 1'b1;
        pass2_q <= cmd_i.pass2;
        sr_q    <= r0_q;
        sc_q    <= c0_q;
      end else if (scan_q) begin
        if (sc_end) begin
          sc_q <= c0_q;
          if (sr_end) scan_q <= 1'b0;
          else        sr_q   <= sr_q + RW'(1);
        end else begin
          sc_q <= sc_q + CW'(1);
        end
      end
    end
  end

  logic [CELL_W-1:0] rdata;

  trs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (waddr),
    .wdata_i ({anomaly_i, sample_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // statistics
  logic signed [SAMPLE_W-1:0] v;
  logic signed [SUMW-1:0]     sum_q;
  logic [NW-1:0]              n_q, anom_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic signed [MEAN_W-1:0]   mean_q;
  logic signed [MEAN_W:0]     d_q;
  logic signed [2*MEAN_W+1:0] prod;
  logic [VAR_W-1:0]           sq_q, var_q;
  logic [DVW-1:0]             acc_q;
  logic                       clr;

  assign v    = rdata[SAMPLE_W-1:0];
  assign prod = d_q * d_q;
  assign clr  = cmd_i.tile_first || cmd_i.tile_next;

  // divider
  div_sel_e              div_sel_q;
  logic [DVW-1:0]        dividend, quot;
  logic [DW-1:0]         divisor;
  logic [SUMW+7:0]       sum_sc, sum_mag;
  logic                  div_done;
  logic [MEAN_W-1:0]     quot_m;

  assign sum_sc  = {sum_q, 8'b0};
  assign sum_mag = sum_q[SUMW-1] ? -sum_sc : sum_sc;
  assign quot_m  = quot[MEAN_W-1:0];

  always_comb begin
    case (cmd_i.div_sel)
      DIV_H: begin
        dividend = DVW'(rows);
        divisor  = DW'(side);
      end
      DIV_W: begin
        dividend = DVW'(cols);
        divisor  = DW'(side);
      end
      DIV_MEAN: begin
        dividend = DVW'(sum_mag);
        divisor  = DW'(n_q);
      end
      default: begin
        dividend = acc_q;
        divisor  = DW'(n_q);
      end
    endcase
  end

  trs_div #(
    .NW (DVW),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) div_sel_q <= cmd_i.div_sel;
    if (clr) begin
      sum_q  <= '0;
      n_q    <= '0;
      anom_q <= '0;
      min_q  <= SAMPLE_MAX;
      max_q  <= SAMPLE_MIN;
      mean_q <= '0;
      acc_q  <= '0;
      var_q  <= '0;
    end else begin
      if (rd_v_q && !pass2_q) begin
        sum_q  <= sum_q + SUMW'(v);
        n_q    <= n_q + NW'(1);
        anom_q <= anom_q + NW'(rdata[CELL_W-1]);
        if (v < min_q) min_q <= v;
        if (v > max_q) max_q <= v;
      end
      if (sq_v_q) acc_q <= acc_q + DVW'(sq_q);
      if (div_done) begin
        case (div_sel_q)
          DIV_H:    h_q    <= RW'(quot);
          DIV_W:    w_q    <= CW'(quot);
          DIV_MEAN: mean_q <= sum_q[SUMW-1] ? -quot_m : quot_m;
          default:  var_q  <= quot[VAR_W-1:0];
        endcase
      end
    end
    // pass 2: (sample*256 - mean), squared in the next stage
    d_q  <= $signed({v[SAMPLE_W-1], v, 8'b0}) - $signed({mean_q[MEAN_W-1], mean_q});
    sq_q <= prod[VAR_W-1:0];
  end

  assign stat_o.load_end   = ld_col_end && ld_row_end;
  assign stat_o.div_done   = div_done;
  assign stat_o.scan_done  = !scan_q && !rd_v_q && !dv_q && !sq_v_q;
  assign stat_o.tile_empty = (r0_q >= r1) || (c0_q >= c1);
  assign stat_o.tile_last  = last_ri && last_ci;

  assign tile_index_o    = IDX_W'(32'(ri_q) * 32'(side) + 32'(ci_q));
  assign tile_mean_o     = mean_q;
  assign tile_variance_o = var_q;
  assign tile_min_o      = min_q;
  assign tile_max_o      = max_q;
  assign anomaly_total_o = CNT_W'(anom_q);
  assign cell_total_o    = CNT_W'(n_q);

endmodule

FILE: rtl/trs_ctrl.sv
// Controller FSM: load phase, tile size divides, per non-empty tile two-pass scan,
// mean/variance divides and result beat. Depends on trs_pkg.
module trs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  input  trs_pkg::trs_stat_t stat_i,
  output trs_pkg::trs_cmd_t  cmd_o
);
  import trs_pkg::*;

  typedef enum logic [14:0] {
    S_LOAD  = 15'b000000000000001,
    S_HGO   = 15'b000000000000010,
    S_HWAIT = 15'b000000000000100,
    S_WGO   = 15'b000000000001000,
    S_WWAIT = 15'b000000000010000,
    S_TINIT = 15'b000000000100000,
    S_S1GO  = 15'b000000001000000,
    S_S1    = 15'b000000010000000,
    S_MGO   = 15'b000000100000000,
    S_MWAIT = 15'b000001000000000,
    S_S2GO  = 15'b000010000000000,
    S_S2    = 15'b000100000000000,
    S_VGO   = 15'b001000000000000,
    S_VWAIT = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_H;
    s_tready_o    = 1'b0;
    m_tvalid_o    = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_we = 1'b1;
          if (stat_i.load_end) state_d = S_HGO;
        end
      end
      S_HGO: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_HWAIT;
      end
      S_HWAIT: if (stat_i.div_done) state_d = S_WGO;
      S_WGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_W;
        state_d       = S_WWAIT;
      end
      S_WWAIT: if (stat_i.div_done) state_d = S_TINIT;
      S_TINIT: begin
        cmd_o.tile_first = 1'b1;
        state_d          = S_S1GO;
      end
      S_S1GO: begin
        if (stat_i.tile_empty) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.scan_go = 1'b1;
          state_d       = S_S1;
        end
      end
      S_S1: if (stat_i.scan_done) state_d = S_MGO;
      S_MGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_MEAN;
        state_d       = S_MWAIT;
      end
      S_MWAIT: if (stat_i.div_done) state_d = S_S2GO;
      S_S2GO: begin
        cmd_o.scan_go = 1'b1;
        cmd_o.pass2   = 1'b1;
        state_d       = S_S2;
      end
      S_S2: if (stat_i.scan_done) state_d = S_VGO;
      S_VGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_VAR;
        state_d       = S_VWAIT;
      end
      S_VWAIT: if (stat_i.div_done) state_d = S_EMIT;
      S_EMIT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          if (stat_i.tile_last) begin
            state_d = S_LOAD;
          end else begin
            cmd_o.tile_next = 1'b1;
            state_d         = S_S1GO;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

FILE: rtl/tiled_region_statistics_unit.sv
// Top level of the tiled region statistics unit: stream ports, config port.
// Depends on trs_pkg, trs_ctrl, trs_dp (trs_ram, trs_div).
//
//  channel   | handshake                   | payload
//  s_axis    | s_axis_tvalid_i/tready_o    | tdata: sample; tuser: anomaly flag
//  m_axis    | m_axis_tvalid_o/tready_i    | tdata: stats; tuser: tile index; tlast
//  cfg       | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Loading accepts a cell beat whenever one is offered, in raster order. The beat
// that completes the grid starts two tile-size divides, then per non-empty tile:
// a scan of its cells, a divide for the mean, a second scan, a divide for the
// variance (each divide runs over a DVW-bit dividend, DVW = 48 + clog2(cells+1),
// one quotient bit per cycle; both scans read the cells through the store read
// port, the second through added difference and square stages). One result
// beat per tile; no input is taken until the last tile's beat is delivered.
// Reset clears control and config only; the cell store needs no clearing.
module tiled_region_statistics_unit #(
  parameter int unsigned MAX_ROWS = trs_pkg::TRS_MAX_ROWS,
  parameter int unsigned MAX_COLS = trs_pkg::TRS_MAX_COLS,
  parameter int unsigned MAX_TPS  = trs_pkg::TRS_MAX_TPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [trs_pkg::SAMPLE_W-1:0]  s_axis_tdata_i,   // [15:0] sample
  input  logic                          s_axis_tuser_i,   // [0] anomaly_flag
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [23:0] mean, [71:24] variance, [87:72] min, [103:88] max,
  // [120:104] anomaly_total, [137:121] cell_total, [143:138] zero
  output logic [trs_pkg::TDO_W-1:0]     m_axis_tdata_o,
  output logic [trs_pkg::IDX_W-1:0]     m_axis_tuser_o,   // [5:0] tile_index
  output logic                          m_axis_tlast_o,   // last_tile
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [trs_pkg::CFG_W-1:0]     cfg_data_i
);
  import trs_pkg::*;

  trs_cmd_t            cmd;
  trs_stat_t           stat;
  logic [MEAN_W-1:0]   mean;
  logic [VAR_W-1:0]    variance;
  logic [SAMPLE_W-1:0] tmin, tmax;
  logic [CNT_W-1:0]    anom, cnt;

  assign cfg_ready_o = 1'b1;

  trs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  trs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_TPS  (MAX_TPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (s_axis_tdata_i),
    .anomaly_i       (s_axis_tuser_i),
    .tile_index_o    (m_axis_tuser_o),
    .tile_mean_o     (mean),
    .tile_variance_o (variance),
    .tile_min_o      (tmin),
    .tile_max_o      (tmax),
    .anomaly_total_o (anom),
    .cell_total_o    (cnt)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, cnt, anom, tmax, tmin, variance, mean};
  assign m_axis_tlast_o = stat.tile_last;

endmodule

FILE: rtl/trs_chk.sv
// Port-level checker for the tiled region statistics unit, bound to the top.
// Depends on trs_pkg.
module trs_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [trs_pkg::TDO_W-1:0]    m_axis_tdata_o,
  input logic [trs_pkg::IDX_W-1:0]    m_axis_tuser_o,
  input logic                         m_axis_tlast_o
);
  import trs_pkg::*;

  logic [CNT_W-1:0]    cnt, anom;
  logic [SAMPLE_W-1:0] tmin, tmax;

  assign cnt  = m_axis_tdata_o[CNT_LSB +: CNT_W];
  assign anom = m_axis_tdata_o[ANOM_LSB +: CNT_W];
  assign tmin = m_axis_tdata_o[MIN_LSB +: SAMPLE_W];
  assign tmax = m_axis_tdata_o[MAX_LSB +: SAMPLE_W];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // no loading while results are pending
  a_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready during result output");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o)
    else $error("result after last tile");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt >= anom)
    else $error("anomaly count exceeds cell count");

  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cnt != '0 |-> $signed(tmin) <= $signed(tmax))
    else $error("tile min above max");

endmodule

bind tiled_region_statistics_unit trs_chk u_trs_chk (.*);
